@@ sv/assert_macros.svh @@
// Assertion helpers for the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");
// Condition that must never be seen on a rising clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

@@ sv/bisu_pkg.sv @@
package bisu_pkg;

  // Field widths
  localparam int ELEM_W    = 11;
  localparam int CNT_W     = 12;
  localparam int WORD_W    = 32;
  localparam int BIT_W     = 5;
  localparam int WIDX_W    = ELEM_W - BIT_W;
  localparam int WORDS_MAX = 1 << WIDX_W;

  // Command codes
  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_TEST   = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_LIST   = 3'd4
  } cmd_e_t;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  // Lowest-member scan of one bitmap word
  typedef struct packed {
    logic              any;
    logic [BIT_W-1:0]  bit_idx;
    logic [WORD_W-1:0] rest;
    logic              last;
  } scan_t;

endpackage

@@ sv/bisu_ram.sv @@
module bisu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/bisu_scan.sv @@
module bisu_scan (
  input  logic [bisu_pkg::WORD_W-1:0] word,
  output bisu_pkg::scan_t             res
);
  import bisu_pkg::*;

  logic [BIT_W-1:0]  idx;
  logic [WORD_W-1:0] rest;

  // Priority encode the lowest set bit
  always_comb begin
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (word[i]) begin
        idx = BIT_W'(i);
      end
    end
  end

  // Clear the lowest set bit: what remains for later transfers
  assign rest = word & (word - WORD_W'(1));

  assign res.any     = |word;
  assign res.bit_idx = idx;
  assign res.rest    = rest;
  assign res.last    = ~|rest;

endmodule

@@ sv/bitmap_integer_set_unit.sv @@
// Bitmap integer set: add, remove, test, clear and list members of a word.
// Each command passes through S_RD (RAM read data, write-back) and S_EMIT
// (result registered, held while out_ready is low); list emits one result
// per member, or a single empty result for a word with no members.
// Reset: clears word valid bits, member count and control; the bitmap RAM
// itself is not swept, invalid words read as zero.
`include "assert_macros.svh"

module bitmap_integer_set_unit #(
  parameter int NUM_WORDS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_cmd,
  input  logic [bisu_pkg::ELEM_W-1:0]  in_element,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_was_member,
  output logic [bisu_pkg::ELEM_W-1:0]  out_member_value,
  output logic                         out_word_empty,
  output logic [bisu_pkg::CNT_W-1:0]   out_member_count,
  output logic                         out_last
);
  import bisu_pkg::*;

  // Only words reachable by an element are stored
  localparam int DEPTH = (NUM_WORDS < WORDS_MAX) ? NUM_WORDS : WORDS_MAX;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [WIDX_W:0]  DEPTH_V = (WIDX_W + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH * WORD_W);

  state_t              state_r, state_nxt;
  cmd_e_t              cmd_r, cmd_nxt;
  logic [ELEM_W-1:0]   elem_r, elem_nxt;
  logic [AW-1:0]       addr_r, addr_nxt;
  logic                inside_r, inside_nxt;
  logic [DEPTH-1:0]    valid_r, valid_nxt;
  logic [WORD_W-1:0]   word_r, word_nxt;
  logic                was_r, was_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_was_r, out_was_nxt;
  logic [ELEM_W-1:0]   out_val_r, out_val_nxt;
  logic                out_empty_r, out_empty_nxt;
  logic [CNT_W-1:0]    out_cnt_r, out_cnt_nxt;
  logic                out_last_r, out_last_nxt;

  logic [WIDX_W-1:0]   in_idx;
  logic [AW-1:0]       in_addr;
  logic                in_inside;
  logic                in_cmd_ok;
  logic                accept;
  logic                can_load;
  logic                emit_final;

  logic                ram_wr_en;
  logic [WORD_W-1:0]   ram_wr_data;
  logic [WORD_W-1:0]   ram_rd_data;
  logic [WORD_W-1:0]   cur_word;
  logic [WORD_W-1:0]   bit_mask;
  logic                cur_was;
  scan_t               scan;

  // Input decode
  assign in_idx    = in_element[ELEM_W-1:BIT_W];
  assign in_addr   = in_idx[AW-1:0];
  assign in_inside = {1'b0, in_idx} < DEPTH_V;
  assign in_cmd_ok = in_cmd inside {CMD_ADD, CMD_REMOVE, CMD_TEST, CMD_CLEAR, CMD_LIST};

  // Handshake
  assign can_load   = !out_valid_r || out_ready;
  assign emit_final = (cmd_r != CMD_LIST) || !scan.any || scan.last;
  assign in_ready   = (state_r == S_IDLE) ||
                      ((state_r == S_EMIT) && can_load && emit_final);
  assign accept     = in_valid && in_ready;

  // Bitmap storage
  bisu_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (addr_r),
    .wr_data (ram_wr_data),
    .rd_en   (accept),
    .rd_addr (in_addr),
    .rd_data (ram_rd_data)
  );

  // Lowest member of the word being listed
  bisu_scan u_scan (
    .word (word_r),
    .res  (scan)
  );

  // Word as seen by the command: invalid or out-of-range words are empty
  assign cur_word = (inside_r && valid_r[addr_r]) ? ram_rd_data : '0;
  assign bit_mask = WORD_W'(1) << elem_r[BIT_W-1:0];
  assign cur_was  = |(cur_word & bit_mask);

  // Sequencer: read, modify/write back, emit
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    elem_nxt      = elem_r;
    addr_nxt      = addr_r;
    inside_nxt    = inside_r;
    valid_nxt     = valid_r;
    word_nxt      = word_r;
    was_nxt       = was_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_was_nxt   = out_was_r;
    out_val_nxt   = out_val_r;
    out_empty_nxt = out_empty_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    ram_wr_en     = 1'b0;
    ram_wr_data   = cur_word;

    case (state_r)
      S_RD: begin
        word_nxt  = cur_word;
        was_nxt   = cur_was;
        state_nxt = S_EMIT;
        case (cmd_r)
          CMD_ADD: begin
            if (inside_r) begin
              ram_wr_en          = 1'b1;
              ram_wr_data        = cur_word | bit_mask;
              valid_nxt[addr_r]  = 1'b1;
              if (!cur_was) begin
                count_nxt = count_r + CNT_W'(1);
              end
            end
          end
          CMD_REMOVE: begin
            if (inside_r) begin
              ram_wr_en          = 1'b1;
              ram_wr_data        = cur_word & ~bit_mask;
              valid_nxt[addr_r]  = 1'b1;
              if (cur_was) begin
                count_nxt = count_r - CNT_W'(1);
              end
            end
          end
          CMD_CLEAR: begin
            valid_nxt = '0;
            count_nxt = '0;
            was_nxt   = 1'b0;
          end
          default: begin
          end
        endcase
      end
      S_EMIT: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = count_r;
          if (cmd_r != CMD_LIST) begin
            out_was_nxt   = was_r;
            out_val_nxt   = '0;
            out_empty_nxt = 1'b0;
            out_last_nxt  = 1'b1;
          end else if (!scan.any) begin
            out_was_nxt   = 1'b0;
            out_val_nxt   = '0;
            out_empty_nxt = 1'b1;
            out_last_nxt  = 1'b1;
          end else begin
            out_was_nxt   = 1'b1;
            out_val_nxt   = {elem_r[ELEM_W-1:BIT_W], scan.bit_idx};
            out_empty_nxt = 1'b0;
            out_last_nxt  = scan.last;
            word_nxt      = scan.rest;
          end
          if (emit_final) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
      end
    endcase

    // New transfer: latch command and start the read
    if (accept) begin
      cmd_nxt    = cmd_e_t'(in_cmd);
      elem_nxt   = in_element;
      addr_nxt   = in_addr;
      inside_nxt = in_inside;
      if (in_cmd_ok) begin
        state_nxt = S_RD;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    elem_r      <= elem_nxt;
    addr_r      <= addr_nxt;
    inside_r    <= inside_nxt;
    word_r      <= word_nxt;
    was_r       <= was_nxt;
    out_was_r   <= out_was_nxt;
    out_val_r   <= out_val_nxt;
    out_empty_r <= out_empty_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_was_member   = out_was_r;
  assign out_member_value = out_val_r;
  assign out_word_empty   = out_empty_r;
  assign out_member_count = out_cnt_r;
  assign out_last         = out_last_r;

  // Checks
  `ASSERT_CLK(a_accept_reads, clk, rst_n, (in_valid && in_ready && in_cmd_ok) |=> (state_r == S_RD))
  `ASSERT_CLK(a_out_from_emit, clk, rst_n, $rose(out_valid) |-> $past(state_r == S_EMIT))
  `ASSERT_NEVER(a_count_bound, clk, rst_n, count_r > CNT_MAX)

endmodule
